>>> sv/humidifier_blower_wet_interlock_unit_macros.svh
// Assertion macros for the humidifier blower wet interlock unit.
// Used by the RTL files that carry concurrent assertions; no dependencies.
`ifndef HUMIDIFIER_BLOWER_WET_INTERLOCK_UNIT_MACROS_SVH
`define HUMIDIFIER_BLOWER_WET_INTERLOCK_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HBWI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HBWI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/hbwi_pkg.sv
// Shared types and constants for the humidifier blower wet interlock unit.
// No dependencies; imported by every module of the block.
package hbwi_pkg;

  typedef enum logic [3:0] {
    REQ_TICK     = 4'd0,
    REQ_SPEED    = 4'd1,
    REQ_TACH     = 4'd2,
    REQ_SCAN     = 4'd3,
    REQ_DRY_GO   = 4'd4,
    REQ_DRY_STOP = 4'd5,
    REQ_STOP_ALL = 4'd6,
    REQ_BEEP     = 4'd7,
    REQ_ARM      = 4'd8
  } req_t;

  typedef enum logic [2:0] {
    CFG_WET_DELAY    = 3'd0,
    CFG_TACH_TIMEOUT = 3'd1,
    CFG_TACH_MIN     = 3'd2,
    CFG_DRY_DUR      = 3'd3,
    CFG_TACH_CHECK   = 3'd4,
    CFG_AUTO_DRY     = 3'd5
  } cfg_idx_t;

  localparam logic [23:0] RST_WET_DELAY    = 24'd10000;
  localparam logic [23:0] RST_TACH_TIMEOUT = 24'd5000;
  localparam logic [15:0] RST_TACH_MIN     = 16'd100;
  localparam logic [23:0] RST_DRY_DUR      = 24'd7200000;

  localparam logic [23:0] RUN_MAX   = 24'hFFFFFF;
  localparam logic [15:0] BEEP_MIN  = 16'd20;
  localparam logic [15:0] BEEP_MAX  = 16'd500;
  localparam logic [7:0]  RESERVED_BITS = 8'hC0;

  localparam logic [2:0] SPEED_OFF = 3'd0;
  localparam logic [2:0] SPEED_DRY = 3'd2;
  localparam logic [2:0] SPEED_MAX = 3'd4;

  localparam logic [2:0] LVL_UNKNOWN = 3'd0;
  localparam logic [2:0] LVL_EMPTY   = 3'd1;
  localparam logic [2:0] LVL_LOW     = 3'd2;
  localparam logic [2:0] LVL_MEDIUM  = 3'd3;
  localparam logic [2:0] LVL_HIGH    = 3'd4;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [2:0]  speed_req;
    logic [15:0] tach_ppm;
    logic [39:0] scan_bytes;
    logic [15:0] beep_ms;
    logic        arm_wet;
  } item_t;

  typedef struct packed {
    logic [23:0] wet_delay_ms;
    logic [23:0] tach_timeout_ms;
    logic [15:0] tach_minimum;
    logic [23:0] dry_duration_ms;
    logic        tach_check_on;
    logic        auto_dry_on;
  } cfg_t;

  typedef struct packed {
    logic        running;
    logic [2:0]  speed_now;
    logic [23:0] run_elapsed;
    logic        humidify_req;
    logic        wet_active;
    logic        wet_this_cycle;
    logic        wet_armed;
    logic        tach_ok_seen;
    logic [15:0] tach_value;
    logic        tach_latched;
    logic        dry_active;
    logic [23:0] dry_left_ms;
    logic [8:0]  beep_left_ms;
    logic        beeping;
    logic [19:0] mask_store;
    logic [2:0]  level_store;
    logic        scanned;
  } st_t;

  typedef struct packed {
    logic        blower_on;
    logic [2:0]  blower_speed;
    logic        wet_on;
    logic        buzzer_on;
    logic        drying;
    logic        fault;
    logic [2:0]  water;
    logic [23:0] dry_ms;
    logic        scan_rejected;
    logic [19:0] key_bits;
  } res_t;

endpackage

>>> sv/humidifier_blower_wet_interlock_unit.sv
// Humidifier blower and wet-output safety interlock, one event per transfer.
// Input channel: in_valid/in_ready with req_type and its operand fields. One
// event (tick, speed, tach, scan, dry start/stop, stop all, beep, arm) per
// transfer. Output channel: out_valid/out_ready carries one status result per
// event: blower state, wet and buzzer outputs, drying, fault, water level,
// dry seconds left, scan rejection and the key mask.
// An accepted event passes through the input register, then the result
// register, before its result is valid. Throughput: one event per cycle,
// sustained while out_ready stays high; the state update is one pass of flag
// logic and counter compares between those two registers, and the dry-seconds
// figure is a constant multiply behind the result register.
// When the receiver stalls, the result register holds its value and the input
// register takes one more event before in_ready drops.
// Configuration: cfg_we with cfg_index and cfg_data writes a register;
// write only while no event is in flight.
// Reset (rst, synchronous, active high) empties both registers, clears all
// interlock state and loads the default configuration.
// Depends on hbwi_pkg, hbwi_cfg, hbwi_core, hbwi_dry_sec and the macro header.
`include "humidifier_blower_wet_interlock_unit_macros.svh"

module humidifier_blower_wet_interlock_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  req_type,
  input  logic [2:0]  speed_req,
  input  logic [15:0] tach_ppm,
  input  logic [39:0] scan_bytes,
  input  logic [15:0] beep_ms,
  input  logic        arm_wet,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        blower_on,
  output logic [2:0]  blower_speed,
  output logic        wet_on,
  output logic        buzzer_on,
  output logic        drying,
  output logic        fault,
  output logic [2:0]  water,
  output logic [14:0] dry_left_s,
  output logic        scan_rejected,
  output logic [19:0] key_bits,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import hbwi_pkg::*;

  cfg_t  cfg;
  item_t s1_item;
  logic  s1_valid;
  logic  s1_move;
  res_t  res;
  res_t  res_q;

  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= '{req_type, speed_req, tach_ppm, scan_bytes, beep_ms, arm_wet};
    end
  end

  hbwi_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hbwi_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (s1_move),
    .item (s1_item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res_q <= res;
    end
  end

  hbwi_dry_sec u_dry_sec (
    .drying     (res_q.drying),
    .dry_ms     (res_q.dry_ms),
    .dry_left_s (dry_left_s)
  );

  assign blower_on     = res_q.blower_on;
  assign blower_speed  = res_q.blower_speed;
  assign wet_on        = res_q.wet_on;
  assign buzzer_on     = res_q.buzzer_on;
  assign drying        = res_q.drying;
  assign fault         = res_q.fault;
  assign water         = res_q.water;
  assign scan_rejected = res_q.scan_rejected;
  assign key_bits      = res_q.key_bits;

  `HBWI_ASSERT_IMPL(a_wet_needs_blower, clk, rst, out_valid && wet_on, blower_on && !drying && !fault, "wet outputs on without a running humidify blower")
  `HBWI_ASSERT_IMPL(a_dry_speed, clk, rst, out_valid && drying, blower_on && (blower_speed == SPEED_DRY), "filter dry without blower at dry speed")
  `HBWI_ASSERT_IMPL(a_ready_when_empty, clk, rst, !out_valid, in_ready, "input stalled while result register is empty")
  `HBWI_ASSERT_NEXT(a_move_gives_result, clk, rst, s1_move, out_valid, "processed event did not produce a result")

endmodule

>>> sv/hbwi_cfg.sv
// Configuration register file of the humidifier blower wet interlock unit.
// Depends on hbwi_pkg for the register index codes and reset values.
module hbwi_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  output hbwi_pkg::cfg_t      cfg
);
  import hbwi_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wet_delay_ms    <= RST_WET_DELAY;
      cfg.tach_timeout_ms <= RST_TACH_TIMEOUT;
      cfg.tach_minimum    <= RST_TACH_MIN;
      cfg.dry_duration_ms <= RST_DRY_DUR;
      cfg.tach_check_on   <= 1'b1;
      cfg.auto_dry_on     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WET_DELAY:    cfg.wet_delay_ms    <= cfg_data;
        CFG_TACH_TIMEOUT: cfg.tach_timeout_ms <= cfg_data;
        CFG_TACH_MIN:     cfg.tach_minimum    <= cfg_data[15:0];
        CFG_DRY_DUR:      cfg.dry_duration_ms <= cfg_data;
        CFG_TACH_CHECK:   cfg.tach_check_on   <= cfg_data[0];
        CFG_AUTO_DRY:     cfg.auto_dry_on     <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> sv/hbwi_core.sv
// Interlock state and its single-pass event update for one registered item.
// Depends on hbwi_pkg for the item, state, result and configuration types.
module hbwi_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  hbwi_pkg::item_t item,
  input  hbwi_pkg::cfg_t  cfg,
  output hbwi_pkg::res_t  res
);
  import hbwi_pkg::*;

  st_t st;
  st_t st_next;
  logic rejected;

  function automatic st_t wet_set(st_t s, logic en);
    st_t r;
    r = s;
    if (en && !s.wet_active) r.wet_this_cycle = 1'b1;
    r.wet_active = en;
    return r;
  endfunction

  function automatic st_t blower_stop(st_t s);
    st_t r;
    r = s;
    r.running      = 1'b0;
    r.speed_now    = SPEED_OFF;
    r.tach_ok_seen = 1'b0;
    return r;
  endfunction

  function automatic st_t blower_start(st_t s, logic [2:0] spd, logic restart);
    st_t r;
    r = s;
    r.running   = 1'b1;
    r.speed_now = spd;
    if (restart) begin
      r.run_elapsed  = '0;
      r.tach_ok_seen = 1'b0;
    end
    return r;
  endfunction

  function automatic st_t dry_begin(st_t s, logic [23:0] dur);
    st_t r;
    r = s;
    r.humidify_req   = 1'b0;
    r = wet_set(r, 1'b0);
    r.wet_this_cycle = 1'b0;
    r.dry_active     = 1'b1;
    r.tach_latched   = 1'b0;
    r.dry_left_ms    = dur;
    r = blower_start(r, SPEED_DRY, 1'b1);
    return r;
  endfunction

  always_comb begin
    logic [2:0]  spd;
    logic        healthy;
    logic        should;
    logic        bad;
    logic [19:0] mask;
    logic [7:0]  v;
    st_next  = st;
    rejected = 1'b0;
    spd      = '0;
    healthy  = 1'b0;
    should   = 1'b0;
    bad      = 1'b0;
    mask     = '0;
    v        = '0;
    case (item.req_type)
      REQ_TICK: begin
        if (st_next.run_elapsed != RUN_MAX) st_next.run_elapsed = st_next.run_elapsed + 24'd1;
        if (st_next.beep_left_ms != '0) st_next.beep_left_ms = st_next.beep_left_ms - 9'd1;
        if (st_next.dry_left_ms != '0) st_next.dry_left_ms = st_next.dry_left_ms - 24'd1;
        if (st_next.beeping && st_next.beep_left_ms == '0) st_next.beeping = 1'b0;
        if (st_next.dry_active && st_next.dry_left_ms == '0) begin
          st_next.dry_active = 1'b0;
          st_next = blower_stop(st_next);
        end
        healthy = st_next.tach_ok_seen && (st_next.tach_value >= cfg.tach_minimum);
        // With tach checking on, a running blower that reaches the timeout without a healthy tach trips the fault.
        if (cfg.tach_check_on && st_next.running && !st_next.tach_latched &&
            st_next.run_elapsed >= cfg.tach_timeout_ms && !healthy) begin
          st_next.tach_latched   = 1'b1;
          st_next.humidify_req   = 1'b0;
          st_next.dry_active     = 1'b0;
          st_next.wet_this_cycle = 1'b0;
          st_next = wet_set(st_next, 1'b0);
          st_next = blower_stop(st_next);
        end
        healthy = st_next.tach_ok_seen && (st_next.tach_value >= cfg.tach_minimum);
        should = st_next.humidify_req && !st_next.dry_active && st_next.wet_armed &&
                 st_next.running && (st_next.run_elapsed >= cfg.wet_delay_ms) &&
                 st_next.scanned && (st_next.level_store >= LVL_LOW) &&
                 (!cfg.tach_check_on || healthy) && !st_next.tach_latched;
        st_next = wet_set(st_next, should);
      end
      REQ_SPEED: begin
        if (item.speed_req == SPEED_OFF) begin
          st_next.humidify_req = 1'b0;
          st_next = wet_set(st_next, 1'b0);
          if (cfg.auto_dry_on && st.wet_this_cycle) begin
            st_next = dry_begin(st_next, cfg.dry_duration_ms);
          end else if (!st_next.dry_active) begin
            st_next = blower_stop(st_next);
          end
        end else begin
          spd = (item.speed_req > SPEED_MAX) ? SPEED_MAX : item.speed_req;
          if (st_next.dry_active) begin
            st_next.dry_active = 1'b0;
            st_next = blower_stop(st_next);
          end
          st_next.humidify_req = 1'b1;
          if (!st_next.running) begin
            st_next.wet_this_cycle = 1'b0;
            st_next.tach_latched   = 1'b0;
            st_next = blower_start(st_next, spd, 1'b1);
          end else if (spd != st_next.speed_now) begin
            st_next = blower_start(st_next, spd, 1'b0);
          end
        end
      end
      REQ_TACH: begin
        st_next.tach_value   = item.tach_ppm;
        st_next.tach_ok_seen = 1'b1;
      end
      REQ_SCAN: begin
        for (int i = 0; i < 5; i++) begin
          v = item.scan_bytes[8*i +: 8];
          if ((v & RESERVED_BITS) != '0) bad = 1'b1;
          mask[2*i]      = v[0];
          mask[2*i + 1]  = v[3];
          mask[2*i + 10] = v[1];
          mask[2*i + 11] = v[4];
        end
        if (bad) begin
          rejected = 1'b1;
        end else begin
          st_next.mask_store = mask;
          st_next.scanned    = 1'b1;
          if (mask[7])       st_next.level_store = LVL_EMPTY;
          else if (mask[18]) st_next.level_store = LVL_LOW;
          else if (!mask[17]) st_next.level_store = LVL_MEDIUM;
          else               st_next.level_store = LVL_HIGH;
        end
      end
      REQ_DRY_GO: begin
        st_next = dry_begin(st_next, cfg.dry_duration_ms);
      end
      REQ_DRY_STOP: begin
        if (st_next.dry_active) begin
          st_next.dry_active = 1'b0;
          st_next = blower_stop(st_next);
        end
      end
      REQ_STOP_ALL: begin
        st_next.humidify_req   = 1'b0;
        st_next.dry_active     = 1'b0;
        st_next.wet_this_cycle = 1'b0;
        st_next.wet_active     = 1'b0;
        st_next.beeping        = 1'b0;
        st_next.beep_left_ms   = '0;
        st_next.running        = 1'b0;
        st_next.speed_now      = SPEED_OFF;
      end
      REQ_BEEP: begin
        st_next.beeping = 1'b1;
        if (item.beep_ms < BEEP_MIN)      st_next.beep_left_ms = BEEP_MIN[8:0];
        else if (item.beep_ms > BEEP_MAX) st_next.beep_left_ms = BEEP_MAX[8:0];
        else                              st_next.beep_left_ms = item.beep_ms[8:0];
      end
      REQ_ARM: begin
        st_next.wet_armed = item.arm_wet;
        if (!item.arm_wet) st_next = wet_set(st_next, 1'b0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step) begin
      st <= st_next;
    end
  end

  always_comb begin
    res.blower_on     = st_next.running;
    res.blower_speed  = st_next.speed_now;
    res.wet_on        = st_next.wet_active;
    res.buzzer_on     = st_next.beeping;
    res.drying        = st_next.dry_active;
    res.fault         = st_next.tach_latched;
    res.water         = st_next.level_store;
    res.dry_ms        = st_next.dry_left_ms;
    res.scan_rejected = rejected;
    res.key_bits      = st_next.mask_store;
  end

endmodule

>>> sv/hbwi_dry_sec.sv
// Converts the registered dry countdown in milliseconds to whole seconds, rounded up, or zero when not drying.
// Depends on hbwi_pkg only through the import convention; no shared types used.
module hbwi_dry_sec (
  input  logic        drying,
  input  logic [23:0] dry_ms,
  output logic [14:0] dry_left_s
);
  import hbwi_pkg::*;

  // floor(n / 1000) as n * ceil(2^35 / 1000) >> 35, exact for n below 2^25.
  localparam int          RECIP_SHIFT = 35;
  localparam logic [25:0] RECIP       = 26'd34359739;
  localparam logic [24:0] ROUND_UP    = 25'd999;

  logic [24:0] num;
  logic [50:0] prod;

  assign num  = {1'b0, dry_ms} + ROUND_UP;
  assign prod = {26'd0, num} * {25'd0, RECIP};
  assign dry_left_s = drying ? prod[RECIP_SHIFT + 14 : RECIP_SHIFT] : 15'd0;

endmodule

>>> tb/testbench.sv
// Self-checking bench for the humidifier blower wet interlock unit.
// A scoreboard class predicts the status after every event; depends on hbwi_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
  import hbwi_pkg::*;

  localparam logic [3:0] REQ_UNUSED_LO = 4'd9;
  localparam logic [3:0] REQ_UNUSED_HI = 4'd15;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic        blower_on;
    logic [2:0]  blower_speed;
    logic        wet_on;
    logic        buzzer_on;
    logic        drying;
    logic        fault;
    logic [2:0]  water;
    logic [14:0] dry_left_s;
    logic        scan_rejected;
    logic [19:0] key_bits;
  } status_t;

  // Tracks the interlock state and holds the status each accepted event must produce.
  class interlock_tracker;
    logic [23:0] wet_delay, tach_timeout, dry_len;
    logic [15:0] tach_min;
    bit          tach_check, auto_dry;

    bit          running, humidify, wet_act, wet_cycle, armed, tach_seen;
    bit          tach_fault, dry_act, beeping, scanned;
    logic [2:0]  speed, level;
    logic [23:0] run_ms, dry_ms;
    logic [15:0] tach_val;
    logic [8:0]  beep_left;
    logic [19:0] keys;

    status_t     status_due[$];
    int unsigned failures;

    function new();
      wet_delay = RST_WET_DELAY;
      tach_timeout = RST_TACH_TIMEOUT;
      tach_min = RST_TACH_MIN;
      dry_len = RST_DRY_DUR;
      tach_check = 1'b1;
      auto_dry = 1'b1;
      {running, humidify, wet_act, wet_cycle, armed, tach_seen} = '0;
      {tach_fault, dry_act, beeping, scanned} = '0;
      speed = SPEED_OFF;
      level = LVL_UNKNOWN;
      run_ms = '0;
      dry_ms = '0;
      tach_val = '0;
      beep_left = '0;
      keys = '0;
      failures = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [23:0] v);
      case (idx)
        CFG_WET_DELAY:    wet_delay = v;
        CFG_TACH_TIMEOUT: tach_timeout = v;
        CFG_TACH_MIN:     tach_min = v[15:0];
        CFG_DRY_DUR:      dry_len = v;
        CFG_TACH_CHECK:   tach_check = v[0];
        CFG_AUTO_DRY:     auto_dry = v[0];
        default: ;
      endcase
    endfunction

    function void stop_blower();
      running = 1'b0;
      speed = SPEED_OFF;
      tach_seen = 1'b0;
    endfunction

    function void start_blower(logic [2:0] spd, bit restart);
      running = 1'b1;
      speed = spd;
      if (restart) begin
        run_ms = '0;
        tach_seen = 1'b0;
      end
    endfunction

    function void set_wet(bit en);
      if (en == wet_act) return;
      wet_act = en;
      if (en) wet_cycle = 1'b1;
    endfunction

    function void begin_dry();
      humidify = 1'b0;
      set_wet(1'b0);
      wet_cycle = 1'b0;
      dry_act = 1'b1;
      tach_fault = 1'b0;
      dry_ms = dry_len;
      start_blower(SPEED_DRY, 1'b1);
    endfunction

    function bit tach_good();
      return tach_seen && tach_val >= tach_min;
    endfunction

    function void speed_event(logic [2:0] req);
      bit go_dry;
      logic [2:0] r;
      if (req == SPEED_OFF) begin
        go_dry = auto_dry && wet_cycle;
        humidify = 1'b0;
        set_wet(1'b0);
        if (go_dry) begin_dry();
        else if (!dry_act) stop_blower();
        return;
      end
      r = (req > SPEED_MAX) ? SPEED_MAX : req;
      if (dry_act) begin
        dry_act = 1'b0;
        stop_blower();
      end
      humidify = 1'b1;
      if (!running) begin
        wet_cycle = 1'b0;
        tach_fault = 1'b0;
        start_blower(r, 1'b1);
      end else if (r != speed) begin
        start_blower(r, 1'b0);
      end
    endfunction

    function void tick_event();
      bit want;
      if (run_ms != RUN_MAX) run_ms++;
      if (beep_left != 0) beep_left--;
      if (dry_ms != 0) dry_ms--;
      if (beeping && beep_left == 0) beeping = 1'b0;
      if (dry_act && dry_ms == 0) begin
        dry_act = 1'b0;
        stop_blower();
      end
      if (tach_check && running && !tach_fault && run_ms >= tach_timeout && !tach_good()) begin
        tach_fault = 1'b1;
        humidify = 1'b0;
        dry_act = 1'b0;
        wet_cycle = 1'b0;
        set_wet(1'b0);
        stop_blower();
      end
      want = humidify && !dry_act && armed && running && run_ms >= wet_delay && scanned &&
             level >= LVL_LOW && (!tach_check || tach_good()) && !tach_fault;
      set_wet(want);
    endfunction

    // Returns 0 when a reserved bit rejects the scan.
    function bit scan_event(logic [39:0] bytes);
      logic [19:0] m;
      logic [7:0]  b;
      int          p;
      m = '0;
      for (int i = 0; i < 5; i++) begin
        b = bytes[8*i +: 8];
        if ((b & RESERVED_BITS) != 0) return 1'b0;
        p = 2 * i;
        m[p] = b[0];
        m[p+1] = b[3];
        m[p+10] = b[1];
        m[p+11] = b[4];
      end
      keys = m;
      scanned = 1'b1;
      if (m[7]) level = LVL_EMPTY;
      else if (m[18]) level = LVL_LOW;
      else if (!m[17]) level = LVL_MEDIUM;
      else level = LVL_HIGH;
      return 1'b1;
    endfunction

    function void note_event(item_t it);
      status_t     s;
      bit          rej;
      logic [15:0] d;
      rej = 1'b0;
      case (it.req_type)
        REQ_TICK:  tick_event();
        REQ_SPEED: speed_event(it.speed_req);
        REQ_TACH: begin
          tach_val = it.tach_ppm;
          tach_seen = 1'b1;
        end
        REQ_SCAN:   rej = !scan_event(it.scan_bytes);
        REQ_DRY_GO: begin_dry();
        REQ_DRY_STOP: begin
          if (dry_act) begin
            dry_act = 1'b0;
            stop_blower();
          end
        end
        REQ_STOP_ALL: begin
          humidify = 1'b0;
          dry_act = 1'b0;
          wet_cycle = 1'b0;
          wet_act = 1'b0;
          beeping = 1'b0;
          beep_left = '0;
          running = 1'b0;
          speed = SPEED_OFF;
        end
        REQ_BEEP: begin
          d = it.beep_ms;
          if (d < BEEP_MIN) d = BEEP_MIN;
          if (d > BEEP_MAX) d = BEEP_MAX;
          beeping = 1'b1;
          beep_left = d[8:0];
        end
        REQ_ARM: begin
          armed = it.arm_wet;
          if (!armed) set_wet(1'b0);
        end
        default: ;
      endcase
      s.blower_on = running;
      s.blower_speed = speed;
      s.wet_on = wet_act;
      s.buzzer_on = beeping;
      s.drying = dry_act;
      s.fault = tach_fault;
      s.water = level;
      s.dry_left_s = dry_act ? 15'((32'(dry_ms) + 32'd999) / 32'd1000) : '0;
      s.scan_rejected = rej;
      s.key_bits = keys;
      status_due.push_back(s);
    endfunction

    function void diff(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s mismatch: expected %0d, got %0d", name, e, a);
        failures++;
      end
    endfunction

    function void check_status(status_t got);
      status_t e;
      if (status_due.size() == 0) begin
        $error("status transfer with no event outstanding");
        failures++;
        return;
      end
      e = status_due.pop_front();
      diff("blower_on", 32'(e.blower_on), 32'(got.blower_on));
      diff("blower_speed", 32'(e.blower_speed), 32'(got.blower_speed));
      diff("wet_on", 32'(e.wet_on), 32'(got.wet_on));
      diff("buzzer_on", 32'(e.buzzer_on), 32'(got.buzzer_on));
      diff("drying", 32'(e.drying), 32'(got.drying));
      diff("fault", 32'(e.fault), 32'(got.fault));
      diff("water", 32'(e.water), 32'(got.water));
      diff("dry_left_s", 32'(e.dry_left_s), 32'(got.dry_left_s));
      diff("scan_rejected", 32'(e.scan_rejected), 32'(got.scan_rejected));
      diff("key_bits", 32'(e.key_bits), 32'(got.key_bits));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid, in_ready;
  logic [3:0]  req_type;
  logic [2:0]  speed_req;
  logic [15:0] tach_ppm;
  logic [39:0] scan_bytes;
  logic [15:0] beep_ms;
  logic        arm_wet;
  logic        out_valid, out_ready;
  logic        blower_on, wet_on, buzzer_on, drying, fault, scan_rejected;
  logic [2:0]  blower_speed, water;
  logic [14:0] dry_left_s;
  logic [19:0] key_bits;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;

  interlock_tracker sb;
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  phase_sent;
  bit  hold_req = 1'b0;
  bit  hold_ack;
  int  hold_left;
  int  quiet_cycles;

  humidifier_blower_wet_interlock_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .speed_req(speed_req), .tach_ppm(tach_ppm),
    .scan_bytes(scan_bytes), .beep_ms(beep_ms), .arm_wet(arm_wet),
    .out_valid(out_valid), .out_ready(out_ready),
    .blower_on(blower_on), .blower_speed(blower_speed), .wet_on(wet_on),
    .buzzer_on(buzzer_on), .drying(drying), .fault(fault), .water(water),
    .dry_left_s(dry_left_s), .scan_rejected(scan_rejected), .key_bits(key_bits),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off whenever hold_req toggles.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_ack <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Results are checked before the event of the same edge is noted; a result
  // always belongs to an event that has passed the input and result registers.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_status({blower_on, blower_speed, wet_on, buzzer_on, drying, fault, water,
                         dry_left_s, scan_rejected, key_bits});
      if (in_valid && in_ready)
        sb.note_event({req_type, speed_req, tach_ppm, scan_bytes, beep_ms, arm_wet});
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic item_t random_event();
    item_t it;
    it.req_type = 4'($urandom_range(0, 15));
    it.speed_req = 3'($urandom);
    it.tach_ppm = 16'($urandom);
    it.scan_bytes = {8'($urandom), 32'($urandom)};
    it.beep_ms = 16'($urandom);
    it.arm_wet = 1'($urandom);
    return it;
  endfunction

  // Random event of any kind, biased so scans often pass and beeps span the clamp.
  function automatic item_t noise_event();
    item_t it;
    it = random_event();
    if ($urandom_range(0, 1) == 0) it.scan_bytes &= 40'h3F3F3F3F3F;
    if ($urandom_range(0, 1) == 0) it.beep_ms = 16'($urandom_range(0, 600));
    return it;
  endfunction

  // A scan that passes and reports a water level of low or better.
  function automatic logic [39:0] good_scan();
    logic [39:0] b;
    b = {8'($urandom), 32'($urandom)} & 40'h3F3F3F3F3F;
    b[27] = 1'b0;
    return b;
  endfunction

  function automatic logic [15:0] healthy_ppm();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return 16'($urandom_range(sb.tach_min, 65535));
  endfunction

  task automatic send(input item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= it.req_type;
    speed_req <= it.speed_req;
    tach_ppm <= it.tach_ppm;
    scan_bytes <= it.scan_bytes;
    beep_ms <= it.beep_ms;
    arm_wet <= it.arm_wet;
    do @(posedge clk); while (!in_ready);
    phase_sent++;
  endtask

  task automatic post(input logic [3:0] kind, input logic [39:0] arg);
    item_t it;
    it = random_event();
    it.req_type = kind;
    case (kind)
      REQ_SPEED: it.speed_req = arg[2:0];
      REQ_TACH:  it.tach_ppm = arg[15:0];
      REQ_SCAN:  it.scan_bytes = arg;
      REQ_BEEP:  it.beep_ms = arg[15:0];
      REQ_ARM:   it.arm_wet = arg[0];
      default: ;
    endcase
    send(it);
  endtask

  task automatic ticks(input int n);
    repeat (n) post(REQ_TICK, '0);
  endtask

  // Stops offering events and waits until every status has come back.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.status_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Upper data bits of the narrow registers carry junk that must be ignored.
  task automatic load_config(input logic [23:0] wd, to, input logic [15:0] tm,
                             input logic [23:0] dd, input bit tc, ad);
    logic [23:0] vals [6];
    cfg_idx_t    idx;
    vals = '{wd, to, {8'($urandom), tm}, dd, {23'($urandom), tc}, {23'($urandom), ad}};
    idx = idx.first();
    for (int k = 0; k < 6; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= vals[k];
      @(posedge clk);
      sb.set_reg(idx, vals[k]);
      idx = idx.next();
    end
    cfg_we <= 1'b0;
  endtask

  // One humidify cycle: arm, scan, run, let the wet gate open, stop, then dry.
  task automatic wet_session();
    int lim;
    post(REQ_ARM, 40'($urandom_range(0, 9) != 0));
    post(REQ_SCAN, good_scan());
    post(REQ_SPEED, 40'($urandom_range(1, 7)));
    if ($urandom_range(0, 4) != 0) post(REQ_TACH, 40'(healthy_ppm()));
    lim = (sb.wet_delay > 20) ? 24 : int'(sb.wet_delay) + 4;
    repeat ($urandom_range(0, lim)) begin
      if ($urandom_range(0, 7) == 0) send(noise_event());
      else post(REQ_TICK, '0);
    end
    case ($urandom_range(0, 9))
      0: post(REQ_STOP_ALL, '0);
      1: post(REQ_DRY_GO, '0);
      default: post(REQ_SPEED, 40'(SPEED_OFF));
    endcase
    lim = (sb.dry_len > 20) ? 12 : int'(sb.dry_len) + 3;
    ticks($urandom_range(0, lim));
    if ($urandom_range(0, 3) == 0) post(REQ_DRY_STOP, '0);
  endtask

  task automatic run_phase(input int idle, input int stall, input int target);
    send_idle_pct = idle;
    stall_pct = stall;
    phase_sent = 0;
    while (phase_sent < target) begin
      if ($urandom_range(0, 3) == 0) send(noise_event());
      else wet_session();
    end
    settle();
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= REQ_TICK;
    speed_req <= '0;
    tach_ppm <= '0;
    scan_bytes <= '0;
    beep_ms <= '0;
    arm_wet <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_WET_DELAY;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: scan decode and rejection, beep clamp, wet gate, auto dry, tach fault.
    load_config(24'd2, 24'd1, 16'd100, 24'd3, 1'b1, 1'b1);
    post(REQ_SCAN, 40'h0);
    post(REQ_SCAN, 40'hFF_FFFF_FFFF);
    post(REQ_SCAN, 40'h3F_3F3F_3F3F);
    post(REQ_SCAN, 40'h40_0000_0000);
    post(REQ_SCAN, 40'h02_0000_0000);
    post(REQ_SCAN, 40'h00_1000_0000);
    post(REQ_BEEP, 40'd0);
    post(REQ_BEEP, 40'd65535);
    post(REQ_ARM, 40'd1);
    post(REQ_SPEED, 40'd7);
    post(REQ_TACH, 40'd65535);
    ticks(3);
    post(REQ_SPEED, 40'd3);
    post(REQ_SPEED, 40'(SPEED_OFF));
    post(REQ_DRY_STOP, '0);
    post(REQ_DRY_GO, '0);
    ticks(4);
    post(REQ_SPEED, 40'd1);
    ticks(2);
    post(REQ_TACH, 40'd0);
    post(REQ_STOP_ALL, '0);
    post(REQ_ARM, 40'd0);
    post(REQ_UNUSED_LO, '0);
    post(REQ_UNUSED_HI, '0);
    settle();

    // Receiver holds off while events keep coming, then the sender waits it out.
    load_config(24'd4, 24'd3, 16'd100, 24'd12, 1'b1, 1'b1);
    hold_req <= ~hold_req;
    repeat (30) send(noise_event());
    settle();
    run_phase(0, 0, 120);

    load_config(24'd0, 24'd0, 16'd0, 24'd0, 1'b0, 1'b0);
    run_phase(53, 0, 110);

    load_config(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1, 1'b1);
    run_phase(0, 53, 110);

    load_config(24'($urandom_range(0, 12)), 24'($urandom_range(0, 10)),
                16'($urandom), 24'($urandom_range(0, 20)), 1'($urandom), 1'($urandom));
    run_phase(11, 11, 110);

    load_config(24'($urandom_range(0, 6)), 24'($urandom_range(2, 8)),
                16'($urandom_range(0, 300)), 24'($urandom_range(1, 15)), 1'b1, 1'b1);
    run_phase(0, 0, 60);
    repeat (8) @(posedge clk);

    if (sb.failures == 0 && sb.status_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
